@@ sv/wsdf_pkg.sv @@
// ----------------------------------------------------------------------------
// wsdf_pkg
// types and constants shared by the frame deframer files
// ----------------------------------------------------------------------------
package wsdf_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic [1:0] frame_class;
      logic       frame_end;
      logic       message_end;
      logic       message_text;
      logic       failed;
      logic [1:0] fail_code;
      logic       peer_closed;
   } rsp_type;

   typedef enum logic [6:0] {
      PH_HDR0    = 7'b0000001,
      PH_HDR1    = 7'b0000010,
      PH_LEN16   = 7'b0000100,
      PH_LEN64   = 7'b0001000,
      PH_MASK    = 7'b0010000,
      PH_PAYLOAD = 7'b0100000,
      PH_STOP    = 7'b1000000
   } phase_type;

   localparam logic [1:0] FAIL_NONE     = 2'd0;
   localparam logic [1:0] FAIL_PROTOCOL = 2'd1;
   localparam logic [1:0] FAIL_TEXT     = 2'd2;
   localparam logic [1:0] FAIL_TOO_BIG  = 2'd3;

   localparam logic [1:0] CLS_DATA  = 2'd0;
   localparam logic [1:0] CLS_PING  = 2'd1;
   localparam logic [1:0] CLS_PONG  = 2'd2;
   localparam logic [1:0] CLS_CLOSE = 2'd3;

   localparam logic [1:0] MSG_NONE   = 2'd0;
   localparam logic [1:0] MSG_TEXT   = 2'd1;
   localparam logic [1:0] MSG_BINARY = 2'd2;

   localparam logic [3:0] OP_CONT   = 4'd0;
   localparam logic [3:0] OP_TEXT   = 4'd1;
   localparam logic [3:0] OP_BINARY = 4'd2;
   localparam logic [3:0] OP_CLOSE  = 4'd8;
   localparam logic [3:0] OP_PING   = 4'd9;
   localparam logic [3:0] OP_PONG   = 4'd10;

   localparam logic [31:0] MAX_MSG_RESET = 32'd1048576;

endpackage

@@ sv/wsdf_if.sv @@
// ----------------------------------------------------------------------------
// wsdf_req_if / wsdf_rsp_if
// valid/ready channels of the frame deframer
// ----------------------------------------------------------------------------
interface wsdf_req_if;
   logic              valid;
   logic              ready;
   wsdf_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface wsdf_rsp_if;
   logic              valid;
   logic              ready;
   wsdf_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/websocket_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// an accepted request byte that yields a result has it in rsp_ff in the next cycle
// throughput: one byte per cycle; the result register is the only stage
// a request is taken whenever the result register is empty or being drained
// reset: synchronous, active high; parser returns to the first header byte
// limit register comes out of reset at 1048576
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   wsdf_req_if.sink    req,
   wsdf_rsp_if.source  rsp
);
   import wsdf_pkg::*;

   localparam int CW = COUNT_WIDTH;

   // parser state
   phase_type        phase_ff, phase_in;
   logic [2:0]       fcount_ff, fcount_in;
   logic [7:0]       hdr0_ff, hdr0_in;
   logic             fin_ff, fin_in;
   logic [3:0]       opcode_ff, opcode_in;
   logic [63:0]      len_acc_ff, len_acc_in;
   logic [CW-1:0]    left_ff, left_in;
   logic [31:0]      mkey_ff, mkey_in;
   logic [1:0]       mphase_ff, mphase_in;
   logic [1:0]       open_ff, open_in;
   logic [CW-1:0]    msg_len_ff, msg_len_in;
   logic [1:0]       u_pend_ff, u_pend_in;
   logic [20:0]      u_cp_ff, u_cp_in;
   logic [1:0]       u_floor_ff, u_floor_in;
   logic [31:0]      max_ff;

   // output register
   logic             rvalid_ff, rvalid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic [7:0]       b;

   // limit is the register capped to the counter range
   logic [63:0]      limit;
   always_comb begin
      if (CW >= 32) limit = {32'd0, max_ff};
      else if (max_ff > 32'((64'd1 << CW) - 64'd1)) limit = (64'd1 << CW) - 64'd1;
      else limit = {32'd0, max_ff};
   end

   assign req.ready   = !rvalid_ff || rsp.ready;
   assign accept      = req.valid && req.ready;
   assign b           = req.payload.in_byte;
   assign rsp.valid   = rvalid_ff;
   assign rsp.payload = rsp_ff;

   // class of the current frame
   function automatic logic [1:0] cls_of(input logic [3:0] op);
      logic [1:0] c;
      c = CLS_DATA;
      if (op == OP_PING) c = CLS_PING;
      else if (op == OP_PONG) c = CLS_PONG;
      else if (op == OP_CLOSE) c = CLS_CLOSE;
      return c;
   endfunction

   // combinational single-byte step
   logic [6:0]    lb;
   logic [63:0]   len_val;
   logic          len_done;
   logic [CW:0]   sum;
   logic [7:0]    v;
   logic [1:0]    cls;
   logic          mt;
   logic          u_ok;
   logic [CW-1:0] left_dec;
   logic [20:0]   cp_new;
   logic [20:0]   floor_v;
   logic          emit;
   logic          fin_frame;
   logic          fin_bv;
   logic [2:0]    fc_inc;

   always_comb begin
      phase_in   = phase_ff;
      fcount_in  = fcount_ff;
      hdr0_in    = hdr0_ff;
      fin_in     = fin_ff;
      opcode_in  = opcode_ff;
      len_acc_in = len_acc_ff;
      left_in    = left_ff;
      mkey_in    = mkey_ff;
      mphase_in  = mphase_ff;
      open_in    = open_ff;
      msg_len_in = msg_len_ff;
      u_pend_in  = u_pend_ff;
      u_cp_in    = u_cp_ff;
      u_floor_in = u_floor_ff;
      rsp_in     = '0;
      emit       = 1'b0;
      fin_frame  = 1'b0;
      fin_bv     = 1'b0;
      len_done   = 1'b0;
      len_val    = '0;
      lb         = b[6:0];
      fc_inc     = fcount_ff + 3'd1;
      cls        = cls_of(opcode_ff);
      mt         = (cls == CLS_DATA) &&
                   (opcode_ff == OP_TEXT || (opcode_ff == OP_CONT && open_ff == MSG_TEXT));
      v          = b ^ mkey_ff[8*(3-mphase_ff) +: 8];
      left_dec   = (left_ff != '0) ? left_ff - CW'(1) : left_ff;
      cp_new     = {u_cp_ff[14:0], v[5:0]};
      u_ok       = 1'b1;
      sum        = '0;
      unique case (u_floor_ff)
         2'd0:    floor_v = 21'h80;
         2'd1:    floor_v = 21'h800;
         default: floor_v = 21'h10000;
      endcase

      unique case (phase_ff)
         PH_HDR0: begin
            hdr0_in  = b;
            phase_in = PH_HDR1;
         end
         PH_HDR1: begin
            fin_in    = hdr0_ff[7];
            opcode_in = hdr0_ff[3:0];
            priority if (!b[7] || (hdr0_ff[6:4] != 3'd0) ||
                         (hdr0_ff[3] && (!hdr0_ff[7] || lb >= 7'd126)) ||
                         !(hdr0_ff[3:0] <= OP_BINARY ||
                           (hdr0_ff[3:0] >= OP_CLOSE && hdr0_ff[3:0] <= OP_PONG)) ||
                         ((hdr0_ff[3:0] == OP_TEXT || hdr0_ff[3:0] == OP_BINARY) &&
                          open_ff != MSG_NONE) ||
                         (hdr0_ff[3:0] == OP_CONT && open_ff == MSG_NONE)) begin
               phase_in = PH_STOP;
               emit     = 1'b1;
               rsp_in.failed    = 1'b1;
               rsp_in.fail_code = FAIL_PROTOCOL;
            end else begin
               if (hdr0_ff[3:0] == OP_TEXT) begin
                  u_pend_in  = '0;
                  u_cp_in    = '0;
                  u_floor_in = '0;
               end
               if ((hdr0_ff[3:0] == OP_TEXT || hdr0_ff[3:0] == OP_BINARY) && !hdr0_ff[7])
                  open_in = hdr0_ff[1:0];
               fcount_in  = '0;
               len_acc_in = '0;
               if (lb < 7'd126) begin
                  len_done = 1'b1;
                  len_val  = {57'd0, lb};
               end else begin
                  phase_in = (lb == 7'd126) ? PH_LEN16 : PH_LEN64;
               end
            end
         end
         PH_LEN16, PH_LEN64: begin
            len_acc_in = {len_acc_ff[55:0], b};
            fcount_in  = fc_inc;
            if (phase_ff == PH_LEN16) begin
               if (fc_inc == 3'd2) begin
                  len_done = 1'b1;
                  len_val  = len_acc_in;
               end
            end else if (fcount_ff == 3'd7) begin
               if (len_acc_in > limit) begin
                  phase_in = PH_STOP;
                  emit     = 1'b1;
                  rsp_in.failed    = 1'b1;
                  rsp_in.fail_code = FAIL_PROTOCOL;
               end else begin
                  len_done = 1'b1;
                  len_val  = len_acc_in;
               end
            end
         end
         PH_MASK: begin
            mkey_in   = {mkey_ff[23:0], b};
            fcount_in = fc_inc;
            if (fcount_ff == 3'd3) begin
               phase_in  = PH_PAYLOAD;
               mphase_in = '0;
               if (left_ff == '0) fin_frame = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            mphase_in = mphase_ff + 2'd1;
            left_in   = left_dec;
            if (mt) begin
               if (u_pend_ff == 2'd0) begin
                  if (!v[7]) begin
                  end else if (v[7:5] == 3'b110) begin
                     u_pend_in = 2'd1; u_cp_in = {16'd0, v[4:0]}; u_floor_in = 2'd0;
                  end else if (v[7:4] == 4'b1110) begin
                     u_pend_in = 2'd2; u_cp_in = {17'd0, v[3:0]}; u_floor_in = 2'd1;
                  end else if (v[7:3] == 5'b11110) begin
                     u_pend_in = 2'd3; u_cp_in = {18'd0, v[2:0]}; u_floor_in = 2'd2;
                  end else u_ok = 1'b0;
               end else if (v[7:6] != 2'b10) begin
                  u_ok = 1'b0;
               end else begin
                  u_cp_in   = cp_new;
                  u_pend_in = u_pend_ff - 2'd1;
                  if (u_pend_ff == 2'd1 &&
                      (cp_new < floor_v || cp_new > 21'h10FFFF ||
                       (cp_new >= 21'hD800 && cp_new <= 21'hDFFF)))
                     u_ok = 1'b0;
               end
            end
            if (!u_ok) begin
               phase_in = PH_STOP;
               emit     = 1'b1;
               rsp_in.failed    = 1'b1;
               rsp_in.fail_code = FAIL_TEXT;
            end else if (left_dec == '0) begin
               fin_frame = 1'b1;
               fin_bv    = (cls != CLS_PONG);
            end else if (cls != CLS_PONG) begin
               emit = 1'b1;
               rsp_in.byte_valid   = 1'b1;
               rsp_in.out_byte     = v;
               rsp_in.frame_class  = cls;
               rsp_in.message_text = mt;
            end
         end
         default: ;
      endcase

      // length known: load the payload counter and check the message size
      if (len_done) begin
         left_in = len_val[CW-1:0];
         sum     = {1'b0, msg_len_ff} + {1'b0, len_val[CW-1:0]};
         if (opcode_in == OP_CONT) begin
            if (64'(sum) > limit) begin
               phase_in = PH_STOP;
               emit     = 1'b1;
               rsp_in   = '0;
               rsp_in.failed    = 1'b1;
               rsp_in.fail_code = FAIL_TOO_BIG;
            end else msg_len_in = sum[CW-1:0];
         end else if (opcode_in <= OP_BINARY && !fin_in) begin
            msg_len_in = len_val[CW-1:0];
         end
         if (!emit) begin
            phase_in  = PH_MASK;
            fcount_in = '0;
            mkey_in   = '0;
            mphase_in = '0;
         end
      end

      // frame completion
      if (fin_frame) begin
         emit = 1'b1;
         if (cls == CLS_DATA && fin_ff && mt && u_pend_in != 2'd0) begin
            phase_in = PH_STOP;
            rsp_in   = '0;
            rsp_in.failed    = 1'b1;
            rsp_in.fail_code = FAIL_TEXT;
         end else begin
            rsp_in.byte_valid   = fin_bv;
            rsp_in.out_byte     = fin_bv ? v : 8'd0;
            rsp_in.frame_class  = cls;
            rsp_in.frame_end    = 1'b1;
            rsp_in.message_text = mt;
            if (cls == CLS_DATA && fin_ff) begin
               rsp_in.message_end = 1'b1;
               open_in    = MSG_NONE;
               msg_len_in = '0;
            end
            if (cls == CLS_CLOSE) begin
               rsp_in.peer_closed = 1'b1;
               phase_in = PH_STOP;
            end else phase_in = PH_HDR0;
         end
      end

      rvalid_in = rvalid_ff;
      if (rsp.ready) rvalid_in = 1'b0;
      if (accept && emit) rvalid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         fcount_ff  <= '0;
         hdr0_ff    <= '0;
         fin_ff     <= '0;
         opcode_ff  <= '0;
         len_acc_ff <= '0;
         left_ff    <= '0;
         mkey_ff    <= '0;
         mphase_ff  <= '0;
         open_ff    <= MSG_NONE;
         msg_len_ff <= '0;
         u_pend_ff  <= '0;
         u_cp_ff    <= '0;
         u_floor_ff <= '0;
         max_ff     <= MAX_MSG_RESET;
         rvalid_ff  <= 1'b0;
      end else begin
         if (csr_we) max_ff <= csr_wdata;
         rvalid_ff <= rvalid_in;
         if (accept) begin
            phase_ff   <= phase_in;
            fcount_ff  <= fcount_in;
            hdr0_ff    <= hdr0_in;
            fin_ff     <= fin_in;
            opcode_ff  <= opcode_in;
            len_acc_ff <= len_acc_in;
            left_ff    <= left_in;
            mkey_ff    <= mkey_in;
            mphase_ff  <= mphase_in;
            open_ff    <= open_in;
            msg_len_ff <= msg_len_in;
            u_pend_ff  <= u_pend_in;
            u_cp_ff    <= u_cp_in;
            u_floor_ff <= u_floor_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept && emit) rsp_ff <= rsp_in;
   end

endmodule

@@ sv/wsdf_checker.sv @@
// ----------------------------------------------------------------------------
// wsdf_checker
// port-level checks of the frame deframer
// ----------------------------------------------------------------------------
module wsdf_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wsdf_pkg::rsp_type rsp_payload
);
   import wsdf_pkg::*;

   logic stopped_ff;
   always_ff @(posedge clock) begin
      if (reset) stopped_ff <= 1'b0;
      else if (rsp_valid && rsp_ready && (rsp_payload.failed || rsp_payload.peer_closed))
         stopped_ff <= 1'b1;
   end

   a_stalled_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_fail_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.failed |->
         !rsp_payload.byte_valid && !rsp_payload.frame_end && rsp_payload.fail_code != FAIL_NONE)
      else $error("failure response carries other fields");

   a_msg_end_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.message_end |->
         rsp_payload.frame_end && rsp_payload.frame_class == CLS_DATA)
      else $error("message end outside a data frame end");

   a_silent_after_stop: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !rsp_valid)
      else $error("response after failure or close");

endmodule

bind websocket_frame_deframer_top wsdf_checker u_wsdf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);
